>>> hdl/tmc_pkg.sv
// Shared types and constants for the TCP MSS option clamp.
package tmc_pkg;

  // Largest option area a header can carry.
  localparam int MAX_OPTION_BYTES = 40;

  // Queue between the parser and the rewrite stage.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Option kinds the parser knows by name.
  localparam logic [7:0] KIND_EOL = 8'd0;
  localparam logic [7:0] KIND_NOP = 8'd1;
  localparam logic [7:0] KIND_MSS = 8'd2;

  // What the rewrite stage must do with one queued word.
  typedef enum logic [1:0] {
    ENT_STRAY,
    ENT_PASS,
    ENT_MSS
  } ent_kind_t;

  // One queued word: a byte to pass, or a whole MSS value to check.
  typedef struct packed {
    ent_kind_t   kind;
    logic        first;
    logic        last;
    logic [7:0]  data;
    logic [7:0]  high;
    logic [15:0] csum_in;
  } ent_t;

endpackage

>>> hdl/tmc_front.sv
// Option parser: walks the option area and classifies each byte.
module tmc_front import tmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  opt_byte,
  input  logic        first,
  input  logic [5:0]  area_len,
  input  logic [15:0] checksum_in,
  output logic        push,
  output ent_t        push_ent
);

  logic [5:0] abl_r, abl_nxt;
  logic [5:0] pos_r, pos_nxt;
  logic [7:0] kind_r, kind_nxt;
  logic [7:0] olen_r, olen_nxt;
  logic [7:0] held_r, held_nxt;
  logic       ps_r, ps_nxt;

  logic [5:0] len_clip;
  logic [5:0] abl_cur;
  logic [5:0] pos_cur;
  logic [7:0] kind_cur;
  logic [7:0] olen_cur;
  logic       ps_cur;
  logic [5:0] pos_inc;
  logic [5:0] abl_dec;
  logic       emit;
  logic       is_mss;

  // Area length clipped into the legal range.
  always_comb begin
    if (area_len == 6'd0) begin
      len_clip = 6'd1;
    end else if (area_len > 6'(MAX_OPTION_BYTES)) begin
      len_clip = 6'(MAX_OPTION_BYTES);
    end else begin
      len_clip = area_len;
    end
  end

  // Parse one byte and decide the next state.
  always_comb begin
    abl_cur  = first ? len_clip : abl_r;
    pos_cur  = first ? 6'd0 : pos_r;
    kind_cur = first ? 8'd0 : kind_r;
    olen_cur = first ? 8'd0 : olen_r;
    ps_cur   = first ? 1'b0 : ps_r;
    pos_inc  = pos_cur + 6'd1;
    abl_dec  = abl_cur - 6'd1;
    is_mss   = (kind_cur == KIND_MSS) && (olen_cur >= 8'd4);

    abl_nxt  = abl_r;
    pos_nxt  = pos_r;
    kind_nxt = kind_r;
    olen_nxt = olen_r;
    held_nxt = held_r;
    ps_nxt   = ps_r;

    emit             = 1'b1;
    push_ent.kind    = ENT_PASS;
    push_ent.first   = first;
    push_ent.last    = 1'b0;
    push_ent.data    = opt_byte;
    push_ent.high    = held_r;
    push_ent.csum_in = checksum_in;

    if (!first && abl_r == 6'd0) begin
      // A byte outside any area passes with no effect on state.
      push_ent.kind = ENT_STRAY;
    end else begin
      pos_nxt  = pos_cur;
      kind_nxt = kind_cur;
      olen_nxt = olen_cur;
      ps_nxt   = ps_cur;
      if (first) begin
        held_nxt = 8'd0;
      end
      priority if (ps_cur) begin
        // Parsing has stopped: bytes pass as they are.
      end else if (pos_cur == 6'd0) begin
        if (opt_byte == KIND_EOL) begin
          ps_nxt = 1'b1;
        end else if (opt_byte != KIND_NOP) begin
          if (abl_cur < 6'd2) begin
            ps_nxt = 1'b1;
          end else begin
            kind_nxt = opt_byte;
            pos_nxt  = 6'd1;
          end
        end
      end else if (pos_cur == 6'd1) begin
        if (opt_byte < 8'd2 || {1'b0, opt_byte} > ({3'd0, abl_cur} + 9'd1)) begin
          ps_nxt  = 1'b1;
          pos_nxt = 6'd0;
        end else begin
          olen_nxt = opt_byte;
          pos_nxt  = (opt_byte == 8'd2) ? 6'd0 : 6'd2;
        end
      end else if (is_mss && pos_cur == 6'd2) begin
        // Hold the high value byte until the low one arrives.
        held_nxt = opt_byte;
        pos_nxt  = 6'd3;
        emit     = 1'b0;
      end else if (is_mss && pos_cur == 6'd3) begin
        push_ent.kind = ENT_MSS;
        pos_nxt       = ({2'd0, pos_inc} >= olen_cur) ? 6'd0 : pos_inc;
      end else begin
        pos_nxt = ({2'd0, pos_inc} >= olen_cur) ? 6'd0 : pos_inc;
      end
      abl_nxt = abl_dec;
      if (abl_dec == 6'd0) begin
        push_ent.last = 1'b1;
        ps_nxt        = 1'b0;
        pos_nxt       = 6'd0;
      end
    end
    push = accept && emit;
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abl_r  <= 6'd0;
      pos_r  <= 6'd0;
      kind_r <= 8'd0;
      olen_r <= 8'd0;
      held_r <= 8'd0;
      ps_r   <= 1'b0;
    end else if (accept) begin
      abl_r  <= abl_nxt;
      pos_r  <= pos_nxt;
      kind_r <= kind_nxt;
      olen_r <= olen_nxt;
      held_r <= held_nxt;
      ps_r   <= ps_nxt;
    end
  end

endmodule

>>> hdl/tmc_queue.sv
// Short word queue between the parser and the rewrite stage.
module tmc_queue import tmc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  ent_t push_ent,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output ent_t head_ent
);

  ent_t         mem [QDEPTH];
  logic [QAW-1:0] wptr_r, wptr_nxt;
  logic [QAW-1:0] rptr_r, rptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_ent;
    end
  end

  // Pointer and fill count update.
  always_comb begin
    wptr_nxt = push ? wptr_r + QAW'(1) : wptr_r;
    rptr_nxt = pop ? rptr_r + QAW'(1) : rptr_r;
    cnt_nxt  = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign full       = (cnt_r == (QAW+1)'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_ent   = mem[rptr_r];

endmodule

>>> hdl/tmc_back.sv
// Rewrite stage: clamps MSS values, fixes the checksum and drives results.
module tmc_back import tmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] mss_limit,
  input  logic        head_valid,
  input  ent_t        head_ent,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [15:0] out_checksum_out,
  output logic        out_rewritten,
  output logic        out_end_of_area
);

  logic [15:0] csum_r, csum_nxt;
  logic        rw_r, rw_nxt;
  logic        phase_r, phase_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic [15:0] oc_r, oc_nxt;
  logic        orw_r, orw_nxt;
  logic        oe_r, oe_nxt;

  logic        can_load;
  logic [15:0] old_val;
  logic        clamp;
  logic [15:0] new_val;
  logic [15:0] base_csum;
  logic [16:0] sum;
  logic [16:0] folded;
  logic [15:0] word_csum;
  logic        word_rw;

  // Clamp decision and incremental ones-complement fix-up.
  always_comb begin
    old_val   = {head_ent.high, head_ent.data};
    clamp     = (head_ent.kind == ENT_MSS) && (mss_limit != 16'd0) && (old_val > mss_limit);
    new_val   = clamp ? mss_limit : old_val;
    base_csum = head_ent.first ? head_ent.csum_in : csum_r;
    sum       = {1'b0, base_csum} + {1'b0, old_val - new_val};
    folded    = {16'd0, sum[16]} + {1'b0, sum[15:0]};
    word_csum = clamp ? folded[15:0] : base_csum;
    word_rw   = clamp || (!head_ent.first && rw_r);
  end

  // Result sequencing into the output register.
  always_comb begin
    can_load  = !ov_r || !out_stall;
    pop       = 1'b0;
    csum_nxt  = csum_r;
    rw_nxt    = rw_r;
    phase_nxt = phase_r;
    ov_nxt    = ov_r && out_stall;
    ob_nxt    = ob_r;
    oc_nxt    = oc_r;
    orw_nxt   = orw_r;
    oe_nxt    = oe_r;
    if (head_valid && can_load) begin
      ov_nxt  = 1'b1;
      ob_nxt  = head_ent.data;
      oc_nxt  = 16'd0;
      orw_nxt = 1'b0;
      oe_nxt  = 1'b0;
      unique case (head_ent.kind)
        ENT_STRAY: begin
          pop = 1'b1;
        end
        ENT_PASS: begin
          pop      = 1'b1;
          csum_nxt = word_csum;
          rw_nxt   = word_rw;
          if (head_ent.last) begin
            oc_nxt  = word_csum;
            orw_nxt = word_rw;
            oe_nxt  = 1'b1;
          end
        end
        ENT_MSS: begin
          if (!phase_r) begin
            // High byte of the value goes first; the word stays queued.
            ob_nxt    = new_val[15:8];
            phase_nxt = 1'b1;
          end else begin
            ob_nxt    = new_val[7:0];
            phase_nxt = 1'b0;
            pop       = 1'b1;
            csum_nxt  = word_csum;
            rw_nxt    = word_rw;
            if (head_ent.last) begin
              oc_nxt  = word_csum;
              orw_nxt = word_rw;
              oe_nxt  = 1'b1;
            end
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csum_r  <= 16'd0;
      rw_r    <= 1'b0;
      phase_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      csum_r  <= csum_nxt;
      rw_r    <= rw_nxt;
      phase_r <= phase_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    ob_r  <= ob_nxt;
    oc_r  <= oc_nxt;
    orw_r <= orw_nxt;
    oe_r  <= oe_nxt;
  end

  assign out_valid        = ov_r;
  assign out_byte         = ob_r;
  assign out_checksum_out = oc_r;
  assign out_rewritten    = orw_r;
  assign out_end_of_area  = oe_r;

endmodule

>>> hdl/tcp_mss_option_clamp.sv
// Top level of the TCP MSS option clamp.
//
// Option bytes enter one per cycle on the input channel while in_stall is
// low; the first byte of a header carries the area length and the TCP
// checksum. The parser takes a byte every cycle that its four-word queue is
// not full, and the rewrite stage sends one result word per cycle from a
// registered output while out_stall is low. Each byte yields one result,
// except an MSS value, whose high byte is held and then sent with the low
// byte as two results, so an unstalled stream averages one byte per cycle.
// The checksum and rewrite flag appear on the result marked end_of_area. A
// limit of zero turns clamping off; write the limit only while idle.
module tcp_mss_option_clamp import tmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_opt_byte,
  input  logic        in_first,
  input  logic [5:0]  in_area_len,
  input  logic [15:0] in_checksum_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [15:0] out_checksum_out,
  output logic        out_rewritten,
  output logic        out_end_of_area
);

  logic [15:0] mss_limit_r;
  logic        accept;
  logic        push;
  ent_t        push_ent;
  logic        pop;
  logic        full;
  logic        head_valid;
  ent_t        head_ent;

  // Limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mss_limit_r <= 16'd0;
    end else if (cfg_wr_en) begin
      mss_limit_r <= cfg_wr_data;
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;

  tmc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .opt_byte    (in_opt_byte),
    .first       (in_first),
    .area_len    (in_area_len),
    .checksum_in (in_checksum_in),
    .push        (push),
    .push_ent    (push_ent)
  );

  tmc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ent   (push_ent),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_ent   (head_ent)
  );

  tmc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .mss_limit        (mss_limit_r),
    .head_valid       (head_valid),
    .head_ent         (head_ent),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_checksum_out (out_checksum_out),
    .out_rewritten    (out_rewritten),
    .out_end_of_area  (out_end_of_area)
  );

endmodule

>>> tb/tcp_mss_option_clamp_test.sv
// Self-checking testbench for the TCP MSS option clamp: directed cases, random traffic, checks.
module tcp_mss_option_clamp_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tmc_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_REPORTS  = 10;

  typedef enum {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

  // One result word as the block should present it.
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] csum;
    logic        rewritten;
    logic        last;
  } clamp_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_opt_byte = '0;
  logic        in_first = 1'b0;
  logic [5:0]  in_area_len = '0;
  logic [15:0] in_checksum_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic [15:0] out_checksum_out;
  logic        out_rewritten;
  logic        out_end_of_area;

  // Predictor state, mirroring the parser of the block.
  logic [15:0] mss_cap = '0;
  logic [5:0]  left_cnt = '0;
  logic [5:0]  opt_pos = '0;
  logic [7:0]  opt_kind = '0;
  logic [7:0]  opt_len = '0;
  logic [7:0]  held_hi = '0;
  logic [15:0] run_csum = '0;
  logic        clamp_seen = 1'b0;
  logic        parse_off = 1'b0;

  clamp_word_t expected_words[$];
  logic [7:0]  area_buf[$];

  int words_in = 0;
  int words_out = 0;
  int headers = 0;
  int clamps = 0;
  int bad_words = 0;
  int in_held_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  event hold_go;
  logic hold_on = 1'b0;

  tcp_mss_option_clamp u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opt_byte      (in_opt_byte),
    .in_first         (in_first),
    .in_area_len      (in_area_len),
    .in_checksum_in   (in_checksum_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_checksum_out (out_checksum_out),
    .out_rewritten    (out_rewritten),
    .out_end_of_area  (out_end_of_area)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Work out the result words that one accepted input word causes.
  function automatic void predict_clamp(logic [7:0] b, logic first, logic [5:0] len,
                                        logic [15:0] csum);
    clamp_word_t w [2];
    int          n;
    logic [15:0] old_mss;
    logic [15:0] new_mss;
    logic [31:0] sum;
    n = 0;
    w[0] = '0;
    w[1] = '0;
    if (first) begin
      // A first word opens a new area and drops whatever was in progress.
      if (len == 0) begin
        left_cnt = 6'd1;
      end else if (len > MAX_OPTION_BYTES) begin
        left_cnt = 6'(MAX_OPTION_BYTES);
      end else begin
        left_cnt = len;
      end
      run_csum = csum;
      clamp_seen = 1'b0;
      parse_off = 1'b0;
      opt_pos = '0;
      opt_kind = '0;
      opt_len = '0;
      held_hi = '0;
      headers++;
    end else if (left_cnt == 0) begin
      // A stray word outside any area passes through and touches no state.
      w[0].data = b;
      expected_words.push_back(w[0]);
      return;
    end

    if (parse_off) begin
      w[0].data = b;
      n = 1;
    end else if (opt_pos == 0) begin
      // Kind byte: end of list stops parsing, a no-op is one byte on its own.
      if (b == KIND_EOL) begin
        parse_off = 1'b1;
      end else if (b != KIND_NOP) begin
        if (left_cnt < 2) begin
          parse_off = 1'b1;
        end else begin
          opt_kind = b;
          opt_pos = 6'd1;
        end
      end
      w[0].data = b;
      n = 1;
    end else if (opt_pos == 1) begin
      // Length byte: too short or running past the area stops parsing.
      if (b < 2 || b > left_cnt + 1) begin
        parse_off = 1'b1;
        opt_pos = '0;
      end else begin
        opt_len = b;
        opt_pos = (b == 8'd2) ? 6'd0 : 6'd2;
      end
      w[0].data = b;
      n = 1;
    end else if (opt_kind == KIND_MSS && opt_len >= 4 && opt_pos == 2) begin
      held_hi = b;
      opt_pos = 6'd3;
    end else begin
      if (opt_kind == KIND_MSS && opt_len >= 4 && opt_pos == 3) begin
        // Low MSS byte: clamp the value and fix the checksum in ones complement.
        old_mss = {held_hi, b};
        new_mss = old_mss;
        if (mss_cap != 0 && old_mss > mss_cap) begin
          new_mss = mss_cap;
          sum = {16'h0, run_csum} + {16'h0, old_mss} - {16'h0, new_mss};
          sum = (sum >> 16) + (sum & 32'h0000_FFFF);
          run_csum = sum[15:0];
          clamp_seen = 1'b1;
          clamps++;
        end
        w[0].data = new_mss[15:8];
        w[1].data = new_mss[7:0];
        n = 2;
      end else begin
        w[0].data = b;
        n = 1;
      end
      // Step to the next byte of the option, or back to a kind byte.
      opt_pos = opt_pos + 6'd1;
      if (opt_pos >= opt_len) begin
        opt_pos = '0;
      end
    end

    // The last byte of the area carries the checksum and the rewrite flag.
    left_cnt = left_cnt - 6'd1;
    if (left_cnt == 0) begin
      if (n > 0) begin
        w[n - 1].csum = run_csum;
        w[n - 1].rewritten = clamp_seen;
        w[n - 1].last = 1'b1;
      end
      parse_off = 1'b0;
      opt_pos = '0;
    end
    for (int i = 0; i < n; i++) begin
      expected_words.push_back(w[i]);
    end
  endfunction

  // Fill area_buf with a well-formed option list of random content.
  function automatic void build_options();
    int          room;
    int          space;
    int          opt_bytes;
    logic [15:0] mss;
    logic [7:0]  kind_b;
    area_buf.delete();
    room = ($urandom_range(2) != 0) ? $urandom_range(4, 16) : $urandom_range(1, MAX_OPTION_BYTES);
    while (area_buf.size() < room) begin
      space = room - area_buf.size();
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          if (space >= 4) begin
            // MSS values cluster around the limit so both sides of it are hit.
            case ($urandom_range(5))
              0: mss = 16'h0000;
              1: mss = 16'hFFFF;
              2: mss = mss_cap;
              3: mss = mss_cap + 16'd1;
              4: mss = mss_cap - 16'd1;
              default: mss = 16'($urandom);
            endcase
            opt_bytes = (space >= 6 && $urandom_range(3) == 0) ?
                        $urandom_range(5, (space < 8) ? space : 8) : 4;
            area_buf.push_back(KIND_MSS);
            area_buf.push_back(8'(opt_bytes));
            area_buf.push_back(mss[15:8]);
            area_buf.push_back(mss[7:0]);
            repeat (opt_bytes - 4) area_buf.push_back(8'($urandom));
          end else begin
            area_buf.push_back(KIND_NOP);
          end
        end
        4, 5: begin
          area_buf.push_back(KIND_NOP);
        end
        6, 7, 8: begin
          if (space >= 2) begin
            kind_b = 8'($urandom_range(3, 255));
            opt_bytes = $urandom_range(2, (space < 10) ? space : 10);
            area_buf.push_back(kind_b);
            area_buf.push_back(8'(opt_bytes));
            repeat (opt_bytes - 2) area_buf.push_back(8'($urandom));
          end else begin
            area_buf.push_back(KIND_NOP);
          end
        end
        default: begin
          // End of list, then padding that must pass untouched.
          area_buf.push_back(KIND_EOL);
          while (area_buf.size() < room) area_buf.push_back(8'($urandom));
        end
      endcase
    end
  endfunction

  // Offer one word, wait for it to be taken, then predict its results.
  task automatic send_word(input logic [7:0] b, input logic first, input logic [5:0] len,
                           input logic [15:0] csum);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opt_byte    <= b;
    in_first       <= first;
    in_area_len    <= len;
    in_checksum_in <= csum;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_clamp(b, first, len, csum);
    words_in++;
  endtask

  // Send the first count words of area_buf as one header's option area.
  task automatic send_area(input logic [5:0] len_field, input logic [15:0] csum,
                           input int count);
    for (int i = 0; i < count; i++) begin
      if (i == 0) begin
        send_word(area_buf[0], 1'b1, len_field, csum);
      end else begin
        send_word(area_buf[i], 1'b0, 6'($urandom), 16'($urandom));
      end
    end
  endtask

  // Stop offering and wait until every expected word has come out.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The limit is only changed while the block is empty.
  task automatic write_limit(input logic [15:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mss_cap = value;
  endtask

  task automatic set_pace(input pace_t pace);
    case (pace)
      PACE_FULL: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      PACE_SEND_IDLE: begin
        send_idle_pct = 75;
        recv_stall_pct = 0;
      end
      PACE_RECV_STALL: begin
        send_idle_pct = 0;
        recv_stall_pct = 75;
      end
      default: begin
        send_idle_pct = 10;
        recv_stall_pct = 10;
      end
    endcase
  endtask

  // Two MSS options: one above the limit at the top value, one equal to it.
  task automatic test_mss_clamp();
    write_limit(16'd536);
    area_buf = '{KIND_MSS, 8'd4, 8'hFF, 8'hFF, KIND_MSS, 8'd4, 8'h02, 8'h18};
    send_area(6'd8, 16'h0000, 8);
  endtask

  // No-op, an MSS of length 3 that is never clamped, then end of list with padding.
  task automatic test_short_mss_and_eol();
    area_buf = '{KIND_NOP, KIND_MSS, 8'd3, 8'hAA, KIND_EOL, 8'h55, 8'h00, 8'hFF};
    send_area(6'd8, 16'hFFFF, 8);
  endtask

  // An area length of zero is one byte; a kind byte there is a short option.
  task automatic test_area_len_zero();
    area_buf = '{8'h05};
    send_area(6'd0, 16'h1234, 1);
  endtask

  // A word without first while no area is open passes with all flags clear.
  task automatic test_stray_byte();
    send_word(8'hFF, 1'b0, 6'h3F, 16'hFFFF);
  endtask

  // A restart drops a held MSS byte; then a length below two and one past the area.
  task automatic test_restart_bad_length();
    area_buf = '{KIND_MSS, 8'd4, 8'h12};
    send_area(6'd6, 16'hA5A5, 3);
    area_buf = '{8'd9, 8'd0, 8'h7F};
    send_area(6'd3, 16'h5A5A, 3);
    area_buf = '{8'd30, 8'd3};
    send_area(6'd2, 16'h0F0F, 2);
  endtask

  // Mostly well-formed areas, with byte soup, stray words and restarts mixed in.
  task automatic test_random_traffic(input logic [15:0] limit, input pace_t pace,
                                     input int n_items);
    int         start;
    int         iter;
    int         cut;
    int         count;
    logic [5:0] len_field;
    write_limit(limit);
    set_pace(pace);
    start = words_in;
    iter = 0;
    while (words_in - start < n_items) begin
      if (iter == 0 || $urandom_range(99) < 6) begin
        // Random bytes under a random area length, oversized lengths among them.
        len_field = (iter == 0) ? 6'($urandom_range(41, 63)) : 6'($urandom);
        if (len_field == 0) begin
          count = 1;
        end else if (len_field > MAX_OPTION_BYTES) begin
          count = MAX_OPTION_BYTES;
        end else begin
          count = len_field;
        end
        area_buf.delete();
        repeat (count) begin
          area_buf.push_back(($urandom_range(1) != 0) ? 8'($urandom_range(5)) : 8'($urandom));
        end
        send_area(len_field, 16'($urandom), count);
      end else if ($urandom_range(99) < 6) begin
        repeat ($urandom_range(1, 3)) begin
          send_word(8'($urandom), 1'b0, 6'($urandom), 16'($urandom));
        end
      end else begin
        // Now and then an area is cut short by the next header.
        if ($urandom_range(99) < 8) begin
          build_options();
          if (area_buf.size() > 1) begin
            cut = $urandom_range(1, area_buf.size() - 1);
            send_area(6'(area_buf.size()), 16'($urandom), cut);
          end
        end
        build_options();
        send_area(6'(area_buf.size()), 16'($urandom), area_buf.size());
      end
      iter++;
    end
  endtask

  // Hold the output off for a long stretch while words keep coming in.
  task automatic test_backpressure();
    int start;
    settle();
    set_pace(PACE_FULL);
    -> hold_go;
    start = words_in;
    while (words_in - start < 60) begin
      build_options();
      send_area(6'(area_buf.size()), 16'($urandom), area_buf.size());
    end
  endtask

  // Long hold-off of the receiver, counted here.
  initial begin
    forever begin
      @(hold_go);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  // Receiver stall and a count of cycles where the block held its input off.
  always @(posedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
    if (in_valid && in_stall) begin
      in_held_cycles++;
    end
  end

  // Compare each accepted result word with the oldest expected one.
  always @(posedge clk) begin
    clamp_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_out++;
      if (expected_words.size() == 0) begin
        if (bad_words < MAX_REPORTS) begin
          $display("Unexpected result word: byte %h checksum %h rewritten %b end %b",
                   out_byte, out_checksum_out, out_rewritten, out_end_of_area);
        end
        bad_words++;
      end else begin
        want = expected_words.pop_front();
        if (out_byte !== want.data || out_checksum_out !== want.csum ||
            out_rewritten !== want.rewritten || out_end_of_area !== want.last) begin
          if (bad_words < MAX_REPORTS) begin
            $display("Mismatch on word %0d: expected byte %h checksum %h rewritten %b end %b",
                     words_out, want.data, want.csum, want.rewritten, want.last);
            $display("                      got byte %h checksum %h rewritten %b end %b",
                     out_byte, out_checksum_out, out_rewritten, out_end_of_area);
          end
          bad_words++;
        end
      end
    end
  end

  // Overall time limit.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_mss_clamp();
    test_short_mss_and_eol();
    test_area_len_zero();
    test_stray_byte();
    test_restart_bad_length();
    test_random_traffic(16'd0, PACE_FULL, 250);
    test_random_traffic(16'd1460, PACE_SEND_IDLE, 250);
    test_random_traffic(16'hFFFF, PACE_RECV_STALL, 250);
    test_random_traffic(16'd1, PACE_BOTH, 250);
    test_random_traffic(16'($urandom), PACE_FULL, 250);
    test_backpressure();
    test_random_traffic(16'd536, PACE_RECV_STALL, 250);
    settle();
    $display("Covered %0d option words in %0d headers, %0d result words, %0d MSS values clamped.",
             words_in, headers, words_out, clamps);
    $display("Limits 0, 1, 536, 1460, 65535 and one random; input held off %0d cycles; %0d bad.",
             in_held_cycles, bad_words);
    if (bad_words == 0 && expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/tmc_pkg.sv
hdl/tmc_front.sv
hdl/tmc_queue.sv
hdl/tmc_back.sv
hdl/tcp_mss_option_clamp.sv
tb/tcp_mss_option_clamp_test.sv
